// ===== sv/sbt_pkg.sv =====
// Shared types and token kind codes for the source byte tokenizer.
package sbt_pkg;

    typedef logic [5:0] kind_t;

    // One result item on the token channel.
    typedef struct packed {
        kind_t       token_kind;
        logic [31:0] start_offset;
        logic [23:0] start_line;
        logic [15:0] start_column;
        logic [31:0] end_offset;
        logic [15:0] end_column;
        logic        last_of_run;
    } token_t;

    localparam kind_t KIND_EOF        = 6'd0;
    localparam kind_t KIND_ERROR      = 6'd1;
    localparam kind_t KIND_KW_FN      = 6'd2;
    localparam kind_t KIND_KW_IF      = 6'd3;
    localparam kind_t KIND_KW_ELSE    = 6'd4;
    localparam kind_t KIND_KW_WHILE   = 6'd5;
    localparam kind_t KIND_KW_FOR     = 6'd6;
    localparam kind_t KIND_KW_RET     = 6'd7;
    localparam kind_t KIND_IDENT      = 6'd8;
    localparam kind_t KIND_PLUS       = 6'd9;
    localparam kind_t KIND_MINUS      = 6'd10;
    localparam kind_t KIND_STAR       = 6'd11;
    localparam kind_t KIND_SLASH      = 6'd12;
    localparam kind_t KIND_PERCENT    = 6'd13;
    localparam kind_t KIND_CARET      = 6'd14;
    localparam kind_t KIND_AMP        = 6'd15;
    localparam kind_t KIND_PIPE       = 6'd16;
    localparam kind_t KIND_TILDE      = 6'd17;
    localparam kind_t KIND_AND_AND    = 6'd18;
    localparam kind_t KIND_OR_OR      = 6'd19;
    localparam kind_t KIND_BANG       = 6'd20;
    localparam kind_t KIND_ASSIGN     = 6'd21;
    localparam kind_t KIND_PLUS_EQ    = 6'd22;
    localparam kind_t KIND_MINUS_EQ   = 6'd23;
    localparam kind_t KIND_STAR_EQ    = 6'd24;
    localparam kind_t KIND_SLASH_EQ   = 6'd25;
    localparam kind_t KIND_PERCENT_EQ = 6'd26;
    localparam kind_t KIND_EQ_EQ      = 6'd27;
    localparam kind_t KIND_NOT_EQ     = 6'd28;
    localparam kind_t KIND_LT         = 6'd29;
    localparam kind_t KIND_GT         = 6'd30;
    localparam kind_t KIND_LE         = 6'd31;
    localparam kind_t KIND_GE         = 6'd32;
    localparam kind_t KIND_DOT        = 6'd33;
    localparam kind_t KIND_DOT2       = 6'd34;
    localparam kind_t KIND_DOT3       = 6'd35;
    localparam kind_t KIND_LPAREN     = 6'd36;
    localparam kind_t KIND_RPAREN     = 6'd37;
    localparam kind_t KIND_LBRACE     = 6'd38;
    localparam kind_t KIND_RBRACE     = 6'd39;
    localparam kind_t KIND_LBRACKET   = 6'd40;
    localparam kind_t KIND_RBRACKET   = 6'd41;
    localparam kind_t KIND_INC        = 6'd42;
    localparam kind_t KIND_DEC        = 6'd43;
    localparam kind_t KIND_SEMI       = 6'd44;
    localparam kind_t KIND_COMMA      = 6'd45;
    localparam kind_t KIND_COLON      = 6'd46;

    // Control characters that have no printable literal form.
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

endpackage

// ===== sv/sbt_if.sv =====
// Valid/ready channel interfaces for source bytes and tokens.
interface sbt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface sbt_token_if
    import sbt_pkg::*;
;
    logic   valid;
    logic   ready;
    token_t token;

    modport source (output valid, output token, input ready);
    modport sink (input valid, input token, output ready);
endinterface

// ===== sv/source_byte_tokenizer_core.sv =====
// Streaming tokenizer: one source byte per request, tokens with positions out.
//
//   channel        dir   payload                                 accepted when
//   source_bytes   in    in_byte                                 valid && ready
//   tokens         out   token (kind, start/end pos, last flag)  valid && ready
//
// A taken byte is held in the input register and is scanned there;
// its results enter a three-entry result queue at the next edge and are offered
// on tokens from then on. One byte per cycle is sustained while tokens.ready
// stays high and each byte yields at most one token.
// A byte that yields two tokens fills two queue slots; the queue drains one
// token per cycle while tokens.ready is high, which sets the rate when many bytes yield two tokens.
// The scanner takes the held byte only while the queue holds at most one
// token, so tokens.ready never reaches source_bytes.ready in the same cycle.
// Reset (rst_n low, asynchronous) empties both stages and restores offset 0,
// line 1, column 0 with the scanner idle.
module source_byte_tokenizer_core
    import sbt_pkg::*;
#(
    parameter int OFFSET_BITS = 32,
    parameter int LINE_BITS   = 24,
    parameter int COLUMN_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    sbt_byte_if.sink     source_bytes,
    sbt_token_if.source  tokens
);

    // Scanner modes: what the pending token is, if any.
    localparam logic [4:0] M_IDLE    = 5'd0;
    localparam logic [4:0] M_WORD    = 5'd1;
    localparam logic [4:0] M_DIGITS  = 5'd2;
    localparam logic [4:0] M_COMMENT = 5'd3;
    localparam logic [4:0] M_DOT     = 5'd4;
    localparam logic [4:0] M_DOT2    = 5'd5;
    localparam logic [4:0] M_GT      = 5'd6;
    localparam logic [4:0] M_LT      = 5'd7;
    localparam logic [4:0] M_ASSIGN  = 5'd8;
    localparam logic [4:0] M_NOT     = 5'd9;
    localparam logic [4:0] M_ADD     = 5'd10;
    localparam logic [4:0] M_SUB     = 5'd11;
    localparam logic [4:0] M_MUL     = 5'd12;
    localparam logic [4:0] M_DIV     = 5'd13;
    localparam logic [4:0] M_MOD     = 5'd14;
    localparam logic [4:0] M_AND     = 5'd15;
    localparam logic [4:0] M_OR      = 5'd16;

    localparam int DEPTH = 3;

    // Widths used to zero-extend or truncate counters onto the fixed fields.
    localparam int OFF_EXT  = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;
    localparam int LINE_EXT = (LINE_BITS > 24) ? LINE_BITS : 24;
    localparam int COL_EXT  = (COLUMN_BITS > 16) ? COLUMN_BITS : 16;

    typedef struct packed {
        kind_t lone;
        logic  hit;
        kind_t hit_kind;
    } op_rule_t;

    // Longest-match rule of an operator mode for the byte after its first char.
    function automatic op_rule_t op_rule(input logic [4:0] mode, input logic [7:0] b);
        op_rule_t r;
        r.hit      = 1'b0;
        r.hit_kind = KIND_ERROR;
        unique case (mode)
            M_GT:
            begin
                r.lone = KIND_GT;
                if (b == "=") begin r.hit = 1'b1; r.hit_kind = KIND_GE; end
            end
            M_LT:
            begin
                r.lone = KIND_LT;
                if (b == "=") begin r.hit = 1'b1; r.hit_kind = KIND_LE; end
            end
            M_ASSIGN:
            begin
                r.lone = KIND_ASSIGN;
                if (b == "=") begin r.hit = 1'b1; r.hit_kind = KIND_EQ_EQ; end
            end
            M_NOT:
            begin
                r.lone = KIND_BANG;
                if (b == "=") begin r.hit = 1'b1; r.hit_kind = KIND_NOT_EQ; end
            end
            M_ADD:
            begin
                r.lone = KIND_PLUS;
                if (b == "+") begin r.hit = 1'b1; r.hit_kind = KIND_INC; end
                else if (b == "=") begin r.hit = 1'b1; r.hit_kind = KIND_PLUS_EQ; end
            end
            M_SUB:
            begin
                r.lone = KIND_MINUS;
                if (b == "-") begin r.hit = 1'b1; r.hit_kind = KIND_DEC; end
                else if (b == "=") begin r.hit = 1'b1; r.hit_kind = KIND_MINUS_EQ; end
            end
            M_MUL:
            begin
                r.lone = KIND_STAR;
                if (b == "=") begin r.hit = 1'b1; r.hit_kind = KIND_STAR_EQ; end
            end
            M_DIV:
            begin
                r.lone = KIND_SLASH;
                if (b == "=") begin r.hit = 1'b1; r.hit_kind = KIND_SLASH_EQ; end
            end
            M_MOD:
            begin
                r.lone = KIND_PERCENT;
                if (b == "=") begin r.hit = 1'b1; r.hit_kind = KIND_PERCENT_EQ; end
            end
            M_AND:
            begin
                r.lone = KIND_AMP;
                if (b == "&") begin r.hit = 1'b1; r.hit_kind = KIND_AND_AND; end
            end
            M_OR:
            begin
                r.lone = KIND_PIPE;
                if (b == "|") begin r.hit = 1'b1; r.hit_kind = KIND_OR_OR; end
            end
            default:
            begin
                r.lone = KIND_ERROR;
            end
        endcase
        return r;
    endfunction

    // Keyword check on the first five letters, low byte first.
    function automatic kind_t word_kind(input logic [39:0] chars, input logic [2:0] len);
        kind_t k;
        k = KIND_IDENT;
        if (len == 3'd2 && chars[15:0] == {"n", "f"})
            k = KIND_KW_FN;
        else if (len == 3'd2 && chars[15:0] == {"f", "i"})
            k = KIND_KW_IF;
        else if (len == 3'd4 && chars[31:0] == {"e", "s", "l", "e"})
            k = KIND_KW_ELSE;
        else if (len == 3'd5 && chars[39:0] == {"e", "l", "i", "h", "w"})
            k = KIND_KW_WHILE;
        else if (len == 3'd3 && chars[23:0] == {"r", "o", "f"})
            k = KIND_KW_FOR;
        else if (len == 3'd3 && chars[23:0] == {"t", "e", "r"})
            k = KIND_KW_RET;
        return k;
    endfunction

    // Input register
    logic       byte_valid_reg;
    logic [7:0] byte_reg;

    // Scanner state
    logic [4:0]             mode_reg, mode_next;
    logic [39:0]            chars_reg, chars_next;
    logic [2:0]             word_len_reg, word_len_next;
    logic [OFFSET_BITS-1:0] tok_off_reg, tok_off_next;
    logic [COLUMN_BITS-1:0] tok_col_reg, tok_col_next;
    logic [OFFSET_BITS-1:0] cur_off_reg, cur_off_next;
    logic [LINE_BITS-1:0]   cur_line_reg, cur_line_next;
    logic [COLUMN_BITS-1:0] cur_col_reg, cur_col_next;

    // Result queue, head in slot 0
    token_t     q_reg [DEPTH];
    token_t     q_next [DEPTH];
    logic [1:0] cnt_reg, cnt_next;

    logic                   process;
    logic                   pop;
    logic [OFFSET_BITS-1:0] off_inc;
    logic [COLUMN_BITS-1:0] col_inc;
    logic                   is_letter;
    logic                   is_digit;
    op_rule_t               rule;

    logic   e1_v, e1_done, e2_v, p2;
    kind_t  e1_k, e2_k;
    token_t r1, r2;
    token_t res [2];
    logic [1:0] res_n;

    function automatic token_t make_token(
        input kind_t                  kind,
        input logic [OFFSET_BITS-1:0] s_off,
        input logic [COLUMN_BITS-1:0] s_col,
        input logic [LINE_BITS-1:0]   line,
        input logic [OFFSET_BITS-1:0] e_off,
        input logic [COLUMN_BITS-1:0] e_col,
        input logic                   last
    );
        token_t                t;
        logic [OFF_EXT-1:0]    so_ext;
        logic [OFF_EXT-1:0]    eo_ext;
        logic [LINE_EXT-1:0]   ln_ext;
        logic [COL_EXT-1:0]    sc_ext;
        logic [COL_EXT-1:0]    ec_ext;
        so_ext = OFF_EXT'(s_off);
        eo_ext = OFF_EXT'(e_off);
        ln_ext = LINE_EXT'(line);
        sc_ext = COL_EXT'(s_col);
        ec_ext = COL_EXT'(e_col);
        t.token_kind   = kind;
        t.start_offset = so_ext[31:0];
        t.start_line   = ln_ext[23:0];
        t.start_column = sc_ext[15:0];
        t.end_offset   = eo_ext[31:0];
        t.end_column   = ec_ext[15:0];
        t.last_of_run  = last;
        return t;
    endfunction

    // The queue gates the scanner by its own fill only.
    assign process            = byte_valid_reg && (cnt_reg <= 2'd1);
    assign source_bytes.ready = !byte_valid_reg || process;
    assign pop                = (cnt_reg != 2'd0) && tokens.ready;
    assign tokens.valid       = (cnt_reg != 2'd0);
    assign tokens.token       = q_reg[0];

    // Saturating position increments
    assign off_inc = (cur_off_reg == {OFFSET_BITS{1'b1}}) ? cur_off_reg
                                                         : cur_off_reg + 1'b1;
    assign col_inc = (cur_col_reg == {COLUMN_BITS{1'b1}}) ? cur_col_reg
                                                         : cur_col_reg + 1'b1;

    assign is_letter = (byte_reg >= "a" && byte_reg <= "z") ||
                       (byte_reg >= "A" && byte_reg <= "Z");
    assign is_digit  = (byte_reg >= "0" && byte_reg <= "9");
    assign rule      = op_rule(mode_reg, byte_reg);

    // Scanner: phase one continues or closes the pending token, phase two
    // takes the byte from the idle state.
    always_comb
    begin
        mode_next     = mode_reg;
        chars_next    = chars_reg;
        word_len_next = word_len_reg;
        tok_off_next  = tok_off_reg;
        tok_col_next  = tok_col_reg;
        cur_off_next  = cur_off_reg;
        cur_line_next = cur_line_reg;
        cur_col_next  = cur_col_reg;
        e1_v          = 1'b0;
        e1_done       = 1'b0;
        e1_k          = KIND_ERROR;
        e2_v          = 1'b0;
        e2_k          = KIND_ERROR;
        p2            = 1'b1;

        unique case (mode_reg)
            M_WORD:
            begin
                if (is_letter)
                begin
                    for (int j = 0; j < 5; j++)
                    begin
                        if (word_len_reg == 3'(j))
                            chars_next[8*j +: 8] = byte_reg;
                    end
                    if (word_len_reg < 3'd6)
                        word_len_next = word_len_reg + 3'd1;
                    p2 = 1'b0;
                end
                else
                begin
                    e1_v = 1'b1;
                    e1_k = word_kind(chars_reg, word_len_reg);
                end
            end
            M_DIGITS:
            begin
                if (is_digit)
                    p2 = 1'b0;
                else
                begin
                    e1_v = 1'b1;
                    e1_k = KIND_IDENT;
                end
            end
            M_COMMENT:
            begin
                // newline and zero byte fall through to the idle handling
                if (byte_reg != CH_LF && byte_reg != CH_NUL)
                    p2 = 1'b0;
            end
            M_DOT:
            begin
                if (byte_reg == ".")
                begin
                    mode_next = M_DOT2;
                    p2        = 1'b0;
                end
                else
                begin
                    e1_v = 1'b1;
                    e1_k = KIND_DOT;
                end
            end
            M_DOT2:
            begin
                e1_v = 1'b1;
                if (byte_reg == ".")
                begin
                    e1_done   = 1'b1;
                    e1_k      = KIND_DOT3;
                    mode_next = M_IDLE;
                    p2        = 1'b0;
                end
                else
                    e1_k = KIND_DOT2;
            end
            M_GT, M_LT, M_ASSIGN, M_NOT, M_ADD, M_SUB, M_MUL, M_DIV, M_MOD,
            M_AND, M_OR:
            begin
                e1_v = 1'b1;
                if (rule.hit)
                begin
                    e1_done   = 1'b1;
                    e1_k      = rule.hit_kind;
                    mode_next = M_IDLE;
                    p2        = 1'b0;
                end
                else
                    e1_k = rule.lone;
            end
            default:
            begin
                // idle: nothing pending
            end
        endcase

        // Every byte consumed in phase one advances the position.
        if (!p2)
        begin
            cur_off_next = off_inc;
            cur_col_next = col_inc;
        end
        else
        begin
            mode_next = M_IDLE;
            unique case (byte_reg)
                CH_NUL:
                begin
                    e2_v          = 1'b1;
                    e2_k          = KIND_EOF;
                    chars_next    = '0;
                    word_len_next = '0;
                    tok_off_next  = '0;
                    tok_col_next  = '0;
                    cur_off_next  = '0;
                    cur_line_next = LINE_BITS'(1);
                    cur_col_next  = '0;
                end
                CH_LF:
                begin
                    cur_off_next  = off_inc;
                    cur_line_next = (cur_line_reg == {LINE_BITS{1'b1}}) ? cur_line_reg
                                                                       : cur_line_reg + 1'b1;
                    cur_col_next  = '0;
                end
                " ", CH_TAB, CH_CR:
                begin
                    cur_off_next = off_inc;
                    cur_col_next = col_inc;
                end
                "#", ".", ">", "<", "=", "!", "+", "-", "*", "/", "%", "&", "|":
                begin
                    unique case (byte_reg)
                        "#":     mode_next = M_COMMENT;
                        ".":     mode_next = M_DOT;
                        ">":     mode_next = M_GT;
                        "<":     mode_next = M_LT;
                        "=":     mode_next = M_ASSIGN;
                        "!":     mode_next = M_NOT;
                        "+":     mode_next = M_ADD;
                        "-":     mode_next = M_SUB;
                        "*":     mode_next = M_MUL;
                        "/":     mode_next = M_DIV;
                        "%":     mode_next = M_MOD;
                        "&":     mode_next = M_AND;
                        default: mode_next = M_OR;
                    endcase
                    tok_off_next = cur_off_reg;
                    tok_col_next = cur_col_reg;
                    cur_off_next = off_inc;
                    cur_col_next = col_inc;
                end
                default:
                begin
                    cur_off_next = off_inc;
                    cur_col_next = col_inc;
                    if (is_letter || is_digit)
                    begin
                        mode_next    = is_letter ? M_WORD : M_DIGITS;
                        chars_next   = {32'd0, byte_reg};
                        word_len_next = 3'd1;
                        tok_off_next = cur_off_reg;
                        tok_col_next = cur_col_reg;
                    end
                    else
                    begin
                        e2_v = 1'b1;
                        unique case (byte_reg)
                            "(":     e2_k = KIND_LPAREN;
                            ")":     e2_k = KIND_RPAREN;
                            "{":     e2_k = KIND_LBRACE;
                            "}":     e2_k = KIND_RBRACE;
                            "[":     e2_k = KIND_LBRACKET;
                            "]":     e2_k = KIND_RBRACKET;
                            "^":     e2_k = KIND_CARET;
                            "~":     e2_k = KIND_TILDE;
                            ";":     e2_k = KIND_SEMI;
                            ",":     e2_k = KIND_COMMA;
                            ":":     e2_k = KIND_COLON;
                            default: e2_k = KIND_ERROR;
                        endcase
                    end
                end
            endcase
        end
    end

    // Build the results: a closed pending token first, then the byte's own.
    always_comb
    begin
        r1 = make_token(e1_k, tok_off_reg, tok_col_reg, cur_line_reg,
                        e1_done ? off_inc : cur_off_reg,
                        e1_done ? col_inc : cur_col_reg, !e2_v);
        r2 = make_token(e2_k, cur_off_reg, cur_col_reg, cur_line_reg,
                        off_inc, col_inc, 1'b1);
        res[0] = e1_v ? r1 : r2;
        res[1] = r2;
        res_n  = {1'b0, e1_v} + {1'b0, e2_v};
    end

    // Result queue: shift out on pop, append new results behind what stays.
    always_comb
    begin
        logic [1:0] cnt_after;
        logic [1:0] rel;
        cnt_after = cnt_reg - {1'b0, pop};
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            q_next[i] = pop ? q_reg[i + 1] : q_reg[i];
        end
        q_next[DEPTH-1] = q_reg[DEPTH-1];
        for (int i = 0; i < DEPTH; i++)
        begin
            rel = 2'(i) - cnt_after;
            if (process && (2'(i) >= cnt_after) && (rel < res_n))
                q_next[i] = res[rel[0]];
        end
        cnt_next = cnt_after + (process ? res_n : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            mode_reg       <= M_IDLE;
            chars_reg      <= '0;
            word_len_reg   <= '0;
            tok_off_reg    <= '0;
            tok_col_reg    <= '0;
            cur_off_reg    <= '0;
            cur_line_reg   <= LINE_BITS'(1);
            cur_col_reg    <= '0;
        end
        else
        begin
            if (source_bytes.valid && source_bytes.ready)
                byte_valid_reg <= 1'b1;
            else if (process)
                byte_valid_reg <= 1'b0;
            cnt_reg <= cnt_next;
            if (process)
            begin
                mode_reg     <= mode_next;
                chars_reg    <= chars_next;
                word_len_reg <= word_len_next;
                tok_off_reg  <= tok_off_next;
                tok_col_reg  <= tok_col_next;
                cur_off_reg  <= cur_off_next;
                cur_line_reg <= cur_line_next;
                cur_col_reg  <= cur_col_next;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (source_bytes.valid && source_bytes.ready)
            byte_reg <= source_bytes.in_byte;
        for (int i = 0; i < DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

`ifndef ASSERT_OFF
    a_room_on_scan: assert property (@(posedge clk) disable iff (!rst_n)
        process |-> cnt_reg <= 2'd1)
        else $error("scan with result queue too full");

    a_two_results_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (process && res_n == 2'd2) |=> cnt_reg >= 2'd2)
        else $error("two results not both queued");

    a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (process && e2_v && e2_k == KIND_EOF) |=>
            (cur_off_reg == '0 && cur_line_reg == LINE_BITS'(1) &&
             cur_col_reg == '0 && mode_reg == M_IDLE))
        else $error("positions not restored after end of file");

    a_word_len: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == M_WORD) |-> (word_len_reg != 3'd0 && word_len_reg <= 3'd6))
        else $error("word length out of range");
`endif

endmodule

// ===== tb/sv/source_byte_tokenizer_core_test.sv =====
// Self-checking testbench for source_byte_tokenizer_core: byte stream in, tokens checked.
`timescale 1ns / 1ps

module source_byte_tokenizer_core_test;
    import sbt_pkg::*;

    // Stimulus size and pacing. The calm tail runs without any idling so the
    // end of the run is reached at full rate.
    localparam int STIM_ITEMS       = 900;
    localparam int CALM_TAIL        = 120;
    // Hold the token channel off once, long enough for the block to fill its
    // result queue and push back on the byte channel.
    localparam int LONG_HOLD_AT     = 150;
    localparam int LONG_HOLD_CYCLES = 400;
    // The block has an input register and a result queue; allow a margin.
    localparam int DRAIN_CYCLES     = 20;
    // Longest legal quiet stretch is the long hold plus one idle burst.
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int MAX_REPORTS      = 40;
    localparam int N_WORDS          = 12;
    localparam int N_OPS            = 38;

    // Marks "no one-byte token" inside the scanner model.
    localparam kind_t NO_KIND = 6'd63;

    // Scanner modes of the model: pending token kinds while one byte of
    // lookahead decides how far an operator or a word reaches.
    typedef enum logic [4:0] {
        ST_IDLE, ST_WORD, ST_DIGITS, ST_COMMENT, ST_DOT, ST_DOT2,
        ST_GT, ST_LT, ST_ASSIGN, ST_NOT, ST_ADD, ST_SUB, ST_MUL, ST_DIV,
        ST_MOD, ST_AND, ST_OR
    } lex_state_t;

    logic clk;
    logic rst_n;

    sbt_byte_if  byte_ch ();
    sbt_token_if tok_ch ();

    source_byte_tokenizer_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .source_bytes (byte_ch),
        .tokens       (tok_ch)
    );

    // Scanner model state: mode, first five letters of the current word
    // (first letter in the low byte), word length saturating at 6, start of
    // the pending token, and the running position.
    lex_state_t  lex_state;
    logic [39:0] word_buf;
    logic [2:0]  word_count;
    logic [31:0] pend_off;
    logic [15:0] pend_col;
    logic [31:0] pos_off;
    logic [23:0] pos_line;
    logic [15:0] pos_col;

    logic [7:0] pending_bytes [$];   // source bytes still to be offered
    token_t     expected_tokens [$]; // tokens the scanner model has produced

    int     directed_items;
    int     mid_drain;
    int     total_items;
    int     bytes_accepted;
    int     tokens_predicted;
    int     tokens_checked;
    int     two_token_bytes;
    int     eof_tokens;
    int     error_count;
    int     quiet_cycles;
    int     kinds_seen;
    bit     kind_hit [64];
    logic   calm;

    // Sender pacing.
    int     src_gap;
    int     src_seg_left;
    bit     src_bursty;
    // Receiver pacing.
    int     sink_hold;
    int     sink_seg_left;
    bit     sink_bursty;
    bit     long_hold_done;

    token_t want_tok;
    token_t got_tok;

    string word_list [N_WORDS] = '{
        "fn", "for", "ret", "if", "else", "while",
        "FN", "Else", "whilex", "fo", "iff", "returned"
    };
    string op_list [N_OPS] = '{
        "+", "-", "*", "/", "%", "^", "&", "|", "~", "&&", "||", "!", "=",
        "+=", "-=", "*=", "/=", "%=", "==", "!=", "<", ">", "<=", ">=",
        ".", "..", "...", "++", "--", "(", ")", "{", "}", "[", "]", ";", ",", ":"
    };

    function automatic bit is_letter(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    task automatic restart_scan();
        lex_state  = ST_IDLE;
        word_buf   = '0;
        word_count = '0;
        pend_off   = '0;
        pend_col   = '0;
        pos_off    = '0;
        pos_line   = 24'd1;
        pos_col    = '0;
    endtask

    // Step past one byte on the current line; both counters saturate.
    task automatic advance_pos();
        if (pos_off != '1) pos_off++;
        if (pos_col != '1) pos_col++;
    endtask

    // A token ends at the current position and shares the current line.
    function automatic token_t make_token(input kind_t k, input logic [31:0] s_off,
                                          input logic [15:0] s_col);
        token_t t;
        t.token_kind   = k;
        t.start_offset = s_off;
        t.start_line   = pos_line;
        t.start_column = s_col;
        t.end_offset   = pos_off;
        t.end_column   = pos_col;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    // Run one accepted byte through the scanner model and queue the tokens
    // it completes: first a flushed pending token, then the byte's own one.
    task automatic predict_tokens(input logic [7:0] b);
        token_t      found [2];
        int          n;
        bit          held;
        kind_t       lone;
        kind_t       k;
        kind_t       single;
        lex_state_t  follow_state;
        logic [31:0] s_off;
        logic [15:0] s_col;
        n    = 0;
        held = 1'b0;
        lone = NO_KIND;
        k    = NO_KIND;

        case (lex_state)
            ST_IDLE: ;
            ST_WORD:
                if (is_letter(b))
                begin
                    if (word_count < 5) word_buf[8 * word_count +: 8] = b;
                    if (word_count < 6) word_count++;
                    advance_pos();
                    held = 1'b1;
                end
                else
                begin
                    // The first letter sits in the low byte, so each keyword
                    // reads back to front here. Only lower case matches.
                    k = KIND_IDENT;
                    case (word_count)
                        3'd2:
                            if (word_buf[15:0] == "nf") k = KIND_KW_FN;
                            else if (word_buf[15:0] == "fi") k = KIND_KW_IF;
                        3'd3:
                            if (word_buf[23:0] == "rof") k = KIND_KW_FOR;
                            else if (word_buf[23:0] == "ter") k = KIND_KW_RET;
                        3'd4:
                            if (word_buf[31:0] == "esle") k = KIND_KW_ELSE;
                        3'd5:
                            if (word_buf[39:0] == "elihw") k = KIND_KW_WHILE;
                        default: ;
                    endcase
                    found[n] = make_token(k, pend_off, pend_col);
                    n++;
                end
            ST_DIGITS:
                if (is_digit(b))
                begin
                    advance_pos();
                    held = 1'b1;
                end
                else
                begin
                    found[n] = make_token(KIND_IDENT, pend_off, pend_col);
                    n++;
                end
            ST_COMMENT:
                // Newline and zero end the comment and are then handled as
                // ordinary bytes, so the newline counts only once.
                if (b != CH_LF && b != CH_NUL)
                begin
                    advance_pos();
                    held = 1'b1;
                end
            ST_DOT:
                if (b == ".")
                begin
                    advance_pos();
                    lex_state = ST_DOT2;
                    held = 1'b1;
                end
                else
                begin
                    found[n] = make_token(KIND_DOT, pend_off, pend_col);
                    n++;
                end
            ST_DOT2:
                if (b == ".")
                begin
                    advance_pos();
                    found[n] = make_token(KIND_DOT3, pend_off, pend_col);
                    n++;
                    lex_state = ST_IDLE;
                    held = 1'b1;
                end
                else
                begin
                    found[n] = make_token(KIND_DOT2, pend_off, pend_col);
                    n++;
                end
            default:
            begin
                // Operator modes: the lone kind, or the longer one when the
                // byte extends it.
                case (lex_state)
                    ST_GT:     begin lone = KIND_GT;      k = (b == "=") ? KIND_GE : lone; end
                    ST_LT:     begin lone = KIND_LT;      k = (b == "=") ? KIND_LE : lone; end
                    ST_ASSIGN: begin lone = KIND_ASSIGN;  k = (b == "=") ? KIND_EQ_EQ : lone; end
                    ST_NOT:    begin lone = KIND_BANG;    k = (b == "=") ? KIND_NOT_EQ : lone; end
                    ST_ADD:
                    begin
                        lone = KIND_PLUS;
                        k = (b == "+") ? KIND_INC : (b == "=") ? KIND_PLUS_EQ : lone;
                    end
                    ST_SUB:
                    begin
                        lone = KIND_MINUS;
                        k = (b == "-") ? KIND_DEC : (b == "=") ? KIND_MINUS_EQ : lone;
                    end
                    ST_MUL:    begin lone = KIND_STAR;    k = (b == "=") ? KIND_STAR_EQ : lone; end
                    ST_DIV:    begin lone = KIND_SLASH;   k = (b == "=") ? KIND_SLASH_EQ : lone; end
                    ST_MOD:    begin lone = KIND_PERCENT; k = (b == "=") ? KIND_PERCENT_EQ : lone; end
                    ST_AND:    begin lone = KIND_AMP;     k = (b == "&") ? KIND_AND_AND : lone; end
                    ST_OR:     begin lone = KIND_PIPE;    k = (b == "|") ? KIND_OR_OR : lone; end
                    default: ;
                endcase
                if (k != lone)
                begin
                    advance_pos();
                    found[n] = make_token(k, pend_off, pend_col);
                    n++;
                    lex_state = ST_IDLE;
                    held = 1'b1;
                end
                else
                begin
                    found[n] = make_token(lone, pend_off, pend_col);
                    n++;
                end
            end
        endcase

        if (!held)
        begin
            lex_state    = ST_IDLE;
            s_off        = pos_off;
            s_col        = pos_col;
            follow_state = ST_IDLE;
            single       = NO_KIND;
            case (b)
                CH_NUL:
                begin
                    // End of file covers the zero byte, then positions restart.
                    advance_pos();
                    found[n] = make_token(KIND_EOF, s_off, s_col);
                    n++;
                    eof_tokens++;
                    restart_scan();
                end
                CH_LF:
                begin
                    if (pos_off != '1) pos_off++;
                    if (pos_line != '1) pos_line++;
                    pos_col = '0;
                end
                " ", CH_TAB, CH_CR: advance_pos();
                "#": follow_state = ST_COMMENT;
                ".": follow_state = ST_DOT;
                ">": follow_state = ST_GT;
                "<": follow_state = ST_LT;
                "=": follow_state = ST_ASSIGN;
                "!": follow_state = ST_NOT;
                "+": follow_state = ST_ADD;
                "-": follow_state = ST_SUB;
                "*": follow_state = ST_MUL;
                "/": follow_state = ST_DIV;
                "%": follow_state = ST_MOD;
                "&": follow_state = ST_AND;
                "|": follow_state = ST_OR;
                "(": single = KIND_LPAREN;
                ")": single = KIND_RPAREN;
                "{": single = KIND_LBRACE;
                "}": single = KIND_RBRACE;
                "[": single = KIND_LBRACKET;
                "]": single = KIND_RBRACKET;
                "^": single = KIND_CARET;
                "~": single = KIND_TILDE;
                ";": single = KIND_SEMI;
                ",": single = KIND_COMMA;
                ":": single = KIND_COLON;
                default:
                    if (is_letter(b))
                    begin
                        follow_state = ST_WORD;
                        word_buf     = {32'd0, b};
                        word_count   = 3'd1;
                    end
                    else if (is_digit(b))
                        follow_state = ST_DIGITS;
                    else
                        single = KIND_ERROR; // a byte with no meaning
            endcase
            if (follow_state != ST_IDLE)
            begin
                pend_off  = s_off;
                pend_col  = s_col;
                lex_state = follow_state;
                advance_pos();
            end
            else if (single != NO_KIND)
            begin
                advance_pos();
                found[n] = make_token(single, s_off, s_col);
                n++;
            end
        end

        if (n > 0) found[n - 1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++) expected_tokens.push_back(found[i]);
        tokens_predicted += n;
        if (n == 2) two_token_bytes++;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch at token %0d: %s got %0d expected %0d",
                     tokens_checked, what, got, want);
    endtask

    task automatic queue_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
    endtask

    // Append one random fragment: mostly well-formed lexemes, some comments,
    // blanks and ends of file, and a share of raw noise bytes.
    task automatic add_random_fragment();
        int pick;
        int len;
        int r;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 18)
            queue_text(word_list[$urandom_range(0, N_WORDS - 1)]);
        else if (pick < 32)
        begin
            len = $urandom_range(1, 8);
            repeat (len)
            begin
                r = $urandom_range(0, 51);
                pending_bytes.push_back(r < 26 ? 8'(8'h61 + r) : 8'(8'h41 + r - 26));
            end
        end
        else if (pick < 42)
        begin
            len = $urandom_range(1, 6);
            repeat (len) pending_bytes.push_back(8'(8'h30 + $urandom_range(0, 9)));
        end
        else if (pick < 62)
            queue_text(op_list[$urandom_range(0, N_OPS - 1)]);
        else if (pick < 80)
        begin
            case ($urandom_range(0, 4))
                0:       pending_bytes.push_back(CH_TAB);
                1:       pending_bytes.push_back(CH_CR);
                2:       pending_bytes.push_back(CH_LF);
                default: pending_bytes.push_back(" ");
            endcase
        end
        else if (pick < 86)
        begin
            // Comment body of any byte but newline and zero, high bytes too.
            pending_bytes.push_back("#");
            len = $urandom_range(0, 10);
            repeat (len)
            begin
                c = 8'($urandom_range(1, 255));
                if (c == CH_LF) c = 8'hFF;
                pending_bytes.push_back(c);
            end
            pending_bytes.push_back($urandom_range(0, 7) == 0 ? CH_NUL : CH_LF);
        end
        else if (pick < 88)
            pending_bytes.push_back(CH_NUL);
        else
            pending_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Byte driver: hold a request until it is taken, then offer the next
    // pending byte unless an idle burst or a drain pause is in progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                predict_tokens(byte_ch.in_byte);
                bytes_accepted++;
            end
            if (src_seg_left == 0)
            begin
                src_seg_left = $urandom_range(20, 120);
                src_bursty   = $urandom_range(0, 2) != 0;
            end
            src_seg_left--;
            if (!byte_ch.valid || byte_ch.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    byte_ch.valid <= 1'b0;
                end
                else if (pending_bytes.size() == 0 ||
                         ((bytes_accepted == directed_items || bytes_accepted == mid_drain) &&
                          tokens_predicted != tokens_checked))
                    // Drop valid: nothing left, or wait for every token so far.
                    byte_ch.valid <= 1'b0;
                else
                begin
                    byte_ch.valid   <= 1'b1;
                    byte_ch.in_byte <= pending_bytes.pop_front();
                    if (src_bursty && !calm && $urandom_range(0, 5) == 0)
                        src_gap = $urandom_range(1, 13);
                end
            end
            calm <= pending_bytes.size() < CALM_TAIL;
        end
    end

    // Token monitor: check every taken token against the oldest expected
    // one, then decide ready for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tok_ch.valid && tok_ch.ready)
            begin
                got_tok = tok_ch.token;
                kind_hit[got_tok.token_kind] = 1'b1;
                if (expected_tokens.size() == 0)
                    report_mismatch("token with nothing expected, kind",
                                    32'(got_tok.token_kind), 32'(NO_KIND));
                else
                begin
                    want_tok = expected_tokens.pop_front();
                    if (got_tok.token_kind !== want_tok.token_kind)
                        report_mismatch("token_kind", 32'(got_tok.token_kind),
                                        32'(want_tok.token_kind));
                    if (got_tok.start_offset !== want_tok.start_offset)
                        report_mismatch("start_offset", got_tok.start_offset,
                                        want_tok.start_offset);
                    if (got_tok.start_line !== want_tok.start_line)
                        report_mismatch("start_line", 32'(got_tok.start_line),
                                        32'(want_tok.start_line));
                    if (got_tok.start_column !== want_tok.start_column)
                        report_mismatch("start_column", 32'(got_tok.start_column),
                                        32'(want_tok.start_column));
                    if (got_tok.end_offset !== want_tok.end_offset)
                        report_mismatch("end_offset", got_tok.end_offset, want_tok.end_offset);
                    if (got_tok.end_column !== want_tok.end_column)
                        report_mismatch("end_column", 32'(got_tok.end_column),
                                        32'(want_tok.end_column));
                    if (got_tok.last_of_run !== want_tok.last_of_run)
                        report_mismatch("last_of_run", 32'(got_tok.last_of_run),
                                        32'(want_tok.last_of_run));
                end
                tokens_checked <= tokens_checked + 1;
            end

            // Hold ready low once for a long stretch while bytes keep coming.
            if (!long_hold_done && tokens_checked >= LONG_HOLD_AT)
            begin
                sink_hold      = LONG_HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (sink_seg_left == 0)
            begin
                sink_seg_left = $urandom_range(20, 120);
                sink_bursty   = $urandom_range(0, 2) != 0;
            end
            sink_seg_left--;
            if (sink_hold > 0)
            begin
                sink_hold--;
                tok_ch.ready <= 1'b0;
            end
            else if (sink_bursty && !calm && $urandom_range(0, 7) == 0)
            begin
                sink_hold = $urandom_range(0, 12);
                tok_ch.ready <= 1'b0;
            end
            else
                tok_ch.ready <= 1'b1;
        end
    end

    // Watchdog: advance a count of cycles without any request taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_ch.valid && byte_ch.ready) || (tok_ch.valid && tok_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: %0d cycles without progress", quiet_cycles);
                $display("[source_byte_tokenizer_core] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        byte_ch.valid    = 1'b0;
        byte_ch.in_byte  = 8'h00;
        tok_ch.ready     = 1'b0;
        calm             = 1'b0;
        bytes_accepted   = 0;
        tokens_predicted = 0;
        tokens_checked   = 0;
        two_token_bytes  = 0;
        eof_tokens       = 0;
        error_count      = 0;
        quiet_cycles     = 0;
        src_gap          = 0;
        src_seg_left     = 0;
        sink_hold        = 0;
        sink_seg_left    = 0;
        long_hold_done   = 1'b0;
        restart_scan();

        // Directed opening: a capitalized keyword-like word, word then digit,
        // a keyword, longest-match operators, a comment closed by newline with
        // a high byte in it, meaningless bytes, a comment closed by end of
        // file, and a keyword flushed together with a bracket.
        queue_text("If7for>=...#c");
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(CH_LF);
        queue_text("@");
        pending_bytes.push_back(8'hFF);
        queue_text("#x");
        pending_bytes.push_back(CH_NUL);
        queue_text("while(");
        directed_items = pending_bytes.size();

        while (pending_bytes.size() < STIM_ITEMS - 1) add_random_fragment();
        // Close with end of file so the last pending token is flushed.
        pending_bytes.push_back(CH_NUL);
        total_items = pending_bytes.size();
        mid_drain   = directed_items + (total_items - directed_items) / 2;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        wait (bytes_accepted == total_items && tokens_checked == tokens_predicted);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_tokens.size() != 0)
            report_mismatch("tokens never delivered", 0, expected_tokens.size());

        kinds_seen = 0;
        foreach (kind_hit[i]) kinds_seen += kind_hit[i];
        $display("scanned %0d source bytes into %0d tokens (%0d end-of-file markers)",
                 bytes_accepted, tokens_checked, eof_tokens);
        $display("saw %0d distinct token kinds; %0d bytes closed two tokens at once",
                 kinds_seen, two_token_bytes);
        if (error_count == 0)
            $display("[source_byte_tokenizer_core] OK");
        else
            $display("[source_byte_tokenizer_core] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
sv/sbt_pkg.sv
sv/sbt_if.sv
sv/source_byte_tokenizer_core.sv
tb/sv/source_byte_tokenizer_core_test.sv
